// File: rtl/core/ntre_pkg.sv
// Shared types and constants for the NDEF text record extractor.
// Holds the controller/datapath command and status structs and the address selects.
// No dependencies.
package ntre_pkg;

  localparam int unsigned MaxImageBytesDef = 64;
  localparam int unsigned ResultLimit      = 64;

  localparam logic [7:0] TnfMask      = 8'h07;
  localparam logic [7:0] TnfWellKnown = 8'h01;
  localparam logic [7:0] SrMask       = 8'h10;
  localparam logic [7:0] TypeText     = 8'h54;
  localparam logic [7:0] LangLenMask  = 8'h1F;
  localparam logic [7:0] TermZero     = 8'h00;
  localparam logic [7:0] TermFe       = 8'hFE;
  localparam logic [7:0] PrintLow     = 8'd32;
  localparam logic [7:0] PrintHigh    = 8'd126;
  localparam logic [7:0] SubstChar    = 8'd46;

  // read address sources, relative to the scan offset or the text pointer
  typedef enum logic [2:0] {
    AddrM3,
    AddrM2,
    AddrM1,
    AddrP0,
    AddrP1,
    AddrK
  } addr_sel_e;

  typedef struct packed {
    logic      load_wr;
    logic      scan_start;
    logic      next_off;
    logic      cap_hdr;
    logic      cap_tlen;
    logic      cap_plen;
    logic      cap_tbyte;
    logic      text_start;
    logic      take_char;
    logic      emit;
    logic      emit_last;
    logic      emit_nf;
    logic      clear;
    addr_sel_e addr_sel;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic rec_ok;
    logic term;
    logic at_end;
    logic lim;
    logic has_pend;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/ntre_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ntre_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/ntre_datapath.sv
// Datapath of the NDEF text record extractor: image store, counters, record
// checks, text pointer and the output register. Depends on ntre_pkg, ntre_ram.
module ntre_datapath #(
  parameter int unsigned MaxImageBytes = ntre_pkg::MaxImageBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ntre_pkg::cmd_t cmd_i,
  output ntre_pkg::sts_t sts_o,
  input  logic [7:0]    data_byte_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    text_char_o,
  output logic          found_o,
  output logic          last_char_o
);
  import ntre_pkg::*;

  localparam int unsigned CW = $clog2(MaxImageBytes + 1);
  localparam int unsigned PW = $clog2(MaxImageBytes + 257);
  localparam int unsigned AW = $clog2(MaxImageBytes);
  localparam int unsigned NW = $clog2(ResultLimit + 1);

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] offset_q, offset_d;
  logic [PW-1:0] k_q, k_d;
  logic [PW-1:0] pend_q, pend_d;
  logic [NW-1:0] n_q, n_d;
  logic          has_pend_q, has_pend_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    hdr_q, tlen_q, plen_q, tbyte_q, pchar_q;
  logic [7:0]    out_char_q, out_char_d;
  logic          out_found_q, out_found_d, out_last_q, out_last_d;

  logic [7:0]    rdata;
  logic [PW-1:0] off_w, cnt_w, pend_w, tstart_w, raddr_w;
  logic          we, out_free;
  logic [7:0]    mapped;

  assign off_w    = PW'(offset_q);
  assign cnt_w    = PW'(count_q);
  assign pend_w   = off_w + PW'(1) + PW'(plen_q);
  assign tstart_w = off_w + PW'(2) + PW'(rdata & LangLenMask);
  assign we       = cmd_i.load_wr && (count_q < CW'(MaxImageBytes));
  assign out_free = !out_valid_q || out_ready_i;
  assign mapped   = (rdata >= PrintLow && rdata <= PrintHigh) ? rdata : SubstChar;

  always_comb begin
    unique case (cmd_i.addr_sel)
      AddrM3:  raddr_w = off_w - PW'(3);
      AddrM2:  raddr_w = off_w - PW'(2);
      AddrM1:  raddr_w = off_w - PW'(1);
      AddrP0:  raddr_w = off_w;
      AddrP1:  raddr_w = off_w + PW'(1);
      AddrK:   raddr_w = k_q;
      default: raddr_w = k_q;
    endcase
  end

  ntre_ram #(
    .Width (8),
    .Depth (MaxImageBytes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (data_byte_i),
    .raddr_i (raddr_w[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    sts_o.in_range = (off_w + PW'(2)) < cnt_w;
    sts_o.rec_ok   = ((hdr_q & TnfMask) == TnfWellKnown) && ((hdr_q & SrMask) != 8'h00) &&
                     (tlen_q == 8'd1) && (tbyte_q == TypeText) && (plen_q != 8'h00) &&
                     (pend_w <= cnt_w) && (tstart_w < pend_w);
    sts_o.term     = (rdata == TermZero) || (rdata == TermFe);
    sts_o.at_end   = (k_q + PW'(1)) == pend_q;
    sts_o.lim      = (n_q + NW'(1)) == NW'(ResultLimit);
    sts_o.has_pend = has_pend_q;
    sts_o.out_free = out_free;
  end

  always_comb begin
    count_d     = count_q;
    offset_d    = offset_q;
    k_d         = k_q;
    pend_d      = pend_q;
    n_d         = n_q;
    has_pend_d  = has_pend_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_found_d = out_found_q;
    out_last_d  = out_last_q;

    if (we) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.scan_start) begin
      offset_d = CW'(3);
    end
    if (cmd_i.next_off) begin
      offset_d = offset_q + CW'(1);
    end
    if (cmd_i.text_start) begin
      k_d        = tstart_w;
      pend_d     = pend_w;
      n_d        = '0;
      has_pend_d = 1'b0;
    end
    if (cmd_i.take_char) begin
      k_d        = k_q + PW'(1);
      n_d        = n_q + NW'(1);
      has_pend_d = 1'b1;
    end
    if (cmd_i.clear) begin
      count_d    = '0;
      offset_d   = '0;
      has_pend_d = 1'b0;
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_char_d  = cmd_i.emit_nf ? 8'h00 : pchar_q;
      out_found_d = !cmd_i.emit_nf;
      out_last_d  = cmd_i.emit_last || cmd_i.emit_nf;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      offset_q    <= '0;
      n_q         <= '0;
      has_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      offset_q    <= offset_d;
      n_q         <= n_d;
      has_pend_q  <= has_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    pend_q      <= pend_d;
    out_char_q  <= out_char_d;
    out_found_q <= out_found_d;
    out_last_q  <= out_last_d;
    if (cmd_i.cap_hdr) begin
      hdr_q <= rdata;
    end
    if (cmd_i.cap_tlen) begin
      tlen_q <= rdata;
    end
    if (cmd_i.cap_plen) begin
      plen_q <= rdata;
    end
    if (cmd_i.cap_tbyte) begin
      tbyte_q <= rdata;
    end
    if (cmd_i.take_char) begin
      pchar_q <= mapped;
    end
  end

  assign out_valid_o = out_valid_q;
  assign text_char_o = out_char_q;
  assign found_o     = out_found_q;
  assign last_char_o = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxImageBytes))
    else $error("image byte count beyond store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result loaded over an untaken result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(ResultLimit))
    else $error("text character count beyond limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_found_q |-> out_char_q >= PrintLow && out_char_q <= PrintHigh)
    else $error("non-printable text character emitted");

endmodule

// File: rtl/core/ntre_ctrl.sv
// Controller state machine of the NDEF text record extractor: image load,
// offset scan, record check and text emission. Depends on ntre_pkg.
module ntre_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  input  ntre_pkg::sts_t sts_i,
  output ntre_pkg::cmd_t cmd_o
);
  import ntre_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;
  localparam logic [3:0] S_RD2   = 4'd3;
  localparam logic [3:0] S_RD3   = 4'd4;
  localparam logic [3:0] S_RD4   = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_TADDR = 4'd7;
  localparam logic [3:0] S_TDATA = 4'd8;
  localparam logic [3:0] S_FLUSH = 4'd9;
  localparam logic [3:0] S_NF    = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_LOAD);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.addr_sel = AddrK;

    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load_wr = 1'b1;
          if (in_last_i) begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.in_range) begin
          cmd_o.addr_sel = AddrM3;
          state_d        = S_RD1;
        end else begin
          state_d = S_NF;
        end
      end
      S_RD1: begin
        cmd_o.cap_hdr  = 1'b1;
        cmd_o.addr_sel = AddrM2;
        state_d        = S_RD2;
      end
      S_RD2: begin
        cmd_o.cap_tlen = 1'b1;
        cmd_o.addr_sel = AddrM1;
        state_d        = S_RD3;
      end
      S_RD3: begin
        cmd_o.cap_plen = 1'b1;
        cmd_o.addr_sel = AddrP0;
        state_d        = S_RD4;
      end
      S_RD4: begin
        cmd_o.cap_tbyte = 1'b1;
        cmd_o.addr_sel  = AddrP1;
        state_d         = S_CHK;
      end
      S_CHK: begin
        // status byte is on the read port here
        if (sts_i.rec_ok) begin
          cmd_o.text_start = 1'b1;
          state_d          = S_TADDR;
        end else begin
          cmd_o.next_off = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_TADDR: begin
        state_d = S_TDATA;
      end
      S_TDATA: begin
        if (!sts_i.has_pend) begin
          if (sts_i.term) begin
            // empty text, resume at the next offset
            cmd_o.next_off = 1'b1;
            state_d        = S_SCAN;
          end else begin
            cmd_o.take_char = 1'b1;
            state_d         = (sts_i.at_end || sts_i.lim) ? S_FLUSH : S_TADDR;
          end
        end else if (sts_i.term) begin
          state_d = S_FLUSH;
        end else if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.take_char = 1'b1;
          state_d         = (sts_i.at_end || sts_i.lim) ? S_FLUSH : S_TADDR;
        end
      end
      S_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          cmd_o.clear     = 1'b1;
          state_d         = S_LOAD;
        end
      end
      S_NF: begin
        if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.emit_nf = 1'b1;
          cmd_o.clear   = 1'b1;
          state_d       = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_wr |-> state_q == S_LOAD)
    else $error("store written outside image load");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TDATA && !sts_i.has_pend |-> !cmd_o.emit)
    else $error("emit without a held character");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_start |=> state_q == S_SCAN)
    else $error("scan did not start after last byte");

endmodule

// File: rtl/core/ndef_text_record_extractor.sv
// NDEF short text record extractor, top level. Depends on ntre_pkg, ntre_ctrl,
// ntre_datapath. Image bytes load at one per cycle while in the load state; after
// the last byte each candidate offset passes a scan state, four header reads and a
// check, and each text character an address and a data state, as the image store
// has a single registered read port. Reset clears the state machine, counters and
// output valid; store contents are left as they are.
module ndef_text_record_extractor #(
  parameter int unsigned MaxImageBytes = ntre_pkg::MaxImageBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // last_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] text_char
  output logic       m_axis_tuser_o,   // [0] found
  output logic       m_axis_tlast_o    // last_char
);
  import ntre_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ntre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ntre_datapath #(
    .MaxImageBytes (MaxImageBytes)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .data_byte_i (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .text_char_o (m_axis_tdata_o),
    .found_o     (m_axis_tuser_o),
    .last_char_o (m_axis_tlast_o)
  );

endmodule
